// File: hw/rtl/sitda_pkg.sv
package sitda_pkg;

    // ASCII codes of the output text
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // BCD digit limit for the add-3 correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic negative;
        logic top_zero;
    } dp_status_t;

endpackage

// File: hw/rtl/sitda_ctrl.sv
module sitda_ctrl
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output dp_cmd_t    cmd,
    input  dp_status_t status,
    output logic       strobe,
    output logic       is_last
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_W = $clog2(NUM_DIGITS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic               started_reg, started_next;
    logic               strobe_reg, strobe_next;
    logic               last_reg, last_next;
    logic               emit_now;

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
        end
    end

    // Drop leading zeros, but always emit the units digit
    assign emit_now = !status.top_zero || started_reg || (dig_cnt_reg == '0);

    // Advance the sequence
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        last_next    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = CNT_W'(VALUE_BITS - 1);
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_W'(NUM_DIGITS - 1);
                    state_next   = status.negative ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                strobe_next   = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (emit_now)
                begin
                    strobe_next  = 1'b1;
                    last_next    = (dig_cnt_reg == '0);
                    started_next = 1'b1;
                end
                if (dig_cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != ST_IDLE);
    assign strobe  = strobe_reg;
    assign is_last = last_reg;

    // A beat only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg != ST_IDLE))
        else $error("strobe without work in progress");

    // The last flag only rides on a beat
    a_last_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> strobe_reg)
        else $error("is_last without strobe");

    // An accepted start begins conversion
    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_CONV))
        else $error("start not taken");

    // The units digit always closes the run
    a_units_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && dig_cnt_reg == '0) |=> (strobe_reg && last_reg))
        else $error("final digit not emitted as last");

endmodule

// File: hw/rtl/sitda_dp.sv
module sitda_dp
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
)
(
    input  logic                         clk,
    input  logic signed [VALUE_BITS-1:0] value,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    output logic [7:0]                   char_code
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic                  neg_reg, neg_next;
    logic [7:0]            char_reg, char_next;
    logic [3:0]            top_digit;

    assign raw       = value;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= BCD_ADJ_MIN)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + BCD_ADJ_ADD;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Load the magnitude, shift it into BCD, set the sign character, then shift digits out
    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        char_next = char_reg;
        if (cmd.load)
        begin
            neg_next = raw[VALUE_BITS-1];
            mag_next = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
            bcd_next = '0;
        end
        else if (cmd.dabble)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
        end
        else if (cmd.emit_sign)
        begin
            char_next = CHAR_MINUS;
        end
        else if (cmd.emit_digit)
        begin
            char_next = CHAR_ZERO + {4'b0000, top_digit};
            bcd_next  = {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
    end

    assign status.negative = neg_reg;
    assign status.top_zero = (top_digit == 4'd0);
    assign char_code       = char_reg;

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Input: a two's complement value is taken at a rising edge with start high
// and busy low. Busy stays high while that value is converted; it falls as the final beat is shown.
// Output: one character per beat, most significant first, each shown for
// exactly one cycle with strobe high; is_last marks the final character.
// A negative value opens with '-', there are no leading zeros, and zero
// gives the single character '0'.
// Sequence: the magnitude is shifted through a shift-add-3 BCD converter, one
// bit per cycle, then the sign is sent if any, then the BCD register is
// scanned one digit per cycle (leading zeros send no beat). The next start
// is taken as soon as busy falls, at the same edge that takes the final
// beat, so a new value is taken only once the previous one is through.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// Reset clears the controller to idle with no beat pending; nothing else
// needs clearing.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         strobe,
    output logic [7:0]                   char_code,
    output logic                         is_last
);

    // Decimal digits needed for a VALUE_BITS-bit magnitude
    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

    dp_cmd_t    cmd;
    dp_status_t status;

    sitda_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .status  (status),
        .strobe  (strobe),
        .is_last (is_last)
    );

    sitda_dp #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .clk       (clk),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .char_code (char_code)
    );

endmodule

// File: tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii
    import sitda_pkg::*;
();

    localparam int VALUE_BITS    = 32;
    localparam int DECIMAL_RADIX = 10;
    localparam int MAX_DIGITS    = 10;
    localparam int IDLE_PERCENT  = 25;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int REPORT_LINES  = 40;
    localparam int BURST_ITEMS   = 60;
    localparam int IDLE_ITEMS    = 190;

    localparam logic [VALUE_BITS-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
    localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE = 32'h8000_0000;

    // One character of decimal text as it should appear on the output
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         strobe;
    logic [7:0]                   char_code;
    logic                         is_last;

    text_char_t text_due[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         sender_idles = 1'b0;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .char_code (char_code),
        .is_last   (is_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LINES)
            $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Queue the text of one value: sign first, then digits most significant first
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] magnitude;
        logic [7:0]            digit_codes[$];
        text_char_t            c;
        magnitude = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        do
        begin
            digit_codes.push_front(CHAR_ZERO + 8'(magnitude % DECIMAL_RADIX));
            magnitude = magnitude / DECIMAL_RADIX;
        end
        while (magnitude != 0);
        if (v[VALUE_BITS-1])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            text_due.push_back(c);
        end
        foreach (digit_codes[i])
        begin
            c.code = digit_codes[i];
            c.last = (i == digit_codes.size() - 1);
            text_due.push_back(c);
        end
    endfunction

    // Offer one value until it is taken with busy low; drop start at random while idling
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        bit offer;
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            offer = !sender_idles || ($urandom_range(0, 99) >= IDLE_PERCENT);
            start <= offer;
            value <= offer ? v : VALUE_BITS'($urandom);
            @(posedge clk);
            taken = start && !busy;
        end
        queue_decimal_text(v);
    endtask

    // Mostly values of a random digit count, some raw 32-bit patterns
    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned           n_digits;
        int unsigned           lo;
        int unsigned           hi;
        bit                    negative;
        logic [VALUE_BITS-1:0] magnitude;
        if ($urandom_range(0, 3) == 0)
            return VALUE_BITS'($urandom);
        n_digits = $urandom_range(1, MAX_DIGITS);
        negative = 1'($urandom_range(0, 1));
        lo = 1;
        repeat (n_digits - 1) lo = lo * DECIMAL_RADIX;
        if (n_digits == MAX_DIGITS)
            hi = negative ? MOST_NEGATIVE : MOST_POSITIVE;
        else
            hi = lo * DECIMAL_RADIX - 1;
        if (n_digits == 1)
            lo = 0;
        magnitude = $urandom_range(hi, lo);
        return negative ? (~magnitude + 1'b1) : magnitude;
    endfunction

    // Compare each output beat with the oldest expected character
    always @(posedge clk)
    begin : check_text
        text_char_t due;
        if (rst_n && strobe)
        begin
            if (text_due.size() == 0)
                report_mismatch($sformatf("character 0x%02h with none expected", char_code));
            else
            begin
                due = text_due.pop_front();
                if (char_code !== due.code)
                    report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                              char_code, due.code));
                if (is_last !== due.last)
                    report_mismatch($sformatf("is_last %b, expected %b on 0x%02h",
                                              is_last, due.last, due.code));
            end
        end
    end

    // Zero, digit-count boundaries, both extremes and alternating bit patterns
    task automatic test_directed();
        logic [VALUE_BITS-1:0] corner[] = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10,
            32'd99, 32'd100, 32'd12345, -32'sd67890,
            32'd999999999, 32'd1000000000, -32'sd1000000000, -32'sd999999999,
            MOST_POSITIVE, MOST_POSITIVE - 1'b1, MOST_NEGATIVE, MOST_NEGATIVE + 1'b1,
            32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA
        };
        sender_idles = 1'b1;
        foreach (corner[i])
            send_value(corner[i]);
    endtask

    // Hold start high so each value is taken the moment busy falls
    task automatic test_back_to_back();
        sender_idles = 1'b0;
        repeat (BURST_ITEMS) send_value(random_value());
    endtask

    // Random gaps land on every phase of the conversion
    task automatic test_random_idle();
        sender_idles = 1'b1;
        repeat (IDLE_ITEMS) send_value(random_value());
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_back_to_back();
        test_random_idle();
        @(negedge clk);
        start <= 1'b0;
        while (text_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
